>>> design/bam_pkg.sv
`default_nettype none
package bam_pkg;

  localparam int unsigned ADDR_W   = 16;
  localparam int unsigned DATA_W   = 8;
  localparam int unsigned OFFSET_W = 21;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned CFG_IDX_W = 1;

  localparam logic [COUNT_W-1:0] SCANLINE_CYCLES = 32'd113;

  typedef enum logic [1:0] {
    OP_CPU_WRITE = 2'd0,
    OP_CPU_MAP   = 2'd1,
    OP_PPU_MAP   = 2'd2,
    OP_TICK      = 2'd3
  } op_e;

  typedef enum logic [2:0] {
    TGT_NONE      = 3'd0,
    TGT_PRG_ROM   = 3'd1,
    TGT_WORK_RAM  = 3'd2,
    TGT_CHR_ROM   = 3'd3,
    TGT_NAMETABLE = 3'd4
  } target_e;

  typedef enum logic [1:0] {
    MIR_VERTICAL   = 2'd0,
    MIR_HORIZONTAL = 2'd1,
    MIR_SINGLE_LO  = 2'd2,
    MIR_SINGLE_HI  = 2'd3
  } mirror_e;

  // Command indices latched by a write to the command window.
  localparam logic [3:0] CMD_CHR_FIRST = 4'd0;
  localparam logic [3:0] CMD_CHR_LAST  = 4'd7;
  localparam logic [3:0] CMD_PRG_FIRST = 4'd8;
  localparam logic [3:0] CMD_PRG_LAST  = 4'd11;
  localparam logic [3:0] CMD_MIRROR    = 4'd12;
  localparam logic [3:0] CMD_IRQ_CTRL  = 4'd13;
  localparam logic [3:0] CMD_COUNT_LO  = 4'd14;
  localparam logic [3:0] CMD_COUNT_HI  = 4'd15;

  // CPU address windows, by address bits 15:13.
  localparam logic [2:0] WIN_WORK_RAM = 3'b011;
  localparam logic [2:0] WIN_COMMAND  = 3'b100;
  localparam logic [2:0] WIN_DATA     = 3'b101;
  localparam logic [2:0] WIN_LAST     = 3'b111;

  localparam logic [5:0] PPU_PALETTE_PAGE = 6'h3F;

  localparam logic [CFG_IDX_W-1:0] CFG_PRG_MASK = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_CHR_MASK = 1'd1;

  typedef struct packed {
    op_e               op;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } item_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] index;
    logic [DATA_W-1:0]    data;
  } cfg_wr_t;

  // Mapper state as seen by the translate logic.
  typedef struct packed {
    logic [3:0][DATA_W-1:0] prg_banks;
    logic [7:0][DATA_W-1:0] chr_banks;
    mirror_e                mirror;
    logic [DATA_W-1:0]      prg_mask;
    logic [DATA_W-1:0]      chr_mask;
    logic                   tick_irq;
  } view_t;

endpackage
`default_nettype wire

>>> design/bam_if.sv
`default_nettype none
interface bam_in_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     operation;
  logic [bam_pkg::ADDR_W-1:0]     address;
  logic [bam_pkg::DATA_W-1:0]     data;

  modport source(output valid, output operation, output address, output data, input ready);
  modport sink(input valid, input operation, input address, input data, output ready);
endinterface

interface bam_out_if;
  logic                           valid;
  logic                           ready;
  logic [2:0]                     target;
  logic [bam_pkg::OFFSET_W-1:0]   offset;
  logic                           irq;

  modport source(output valid, output target, output offset, output irq, input ready);
  modport sink(input valid, input target, input offset, input irq, output ready);
endinterface

interface bam_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [bam_pkg::CFG_IDX_W-1:0]  index;
  logic [bam_pkg::DATA_W-1:0]     data;

  modport source(output valid, output index, output data, input ready);
  modport sink(input valid, input index, input data, output ready);
endinterface
`default_nettype wire

>>> design/banked_address_mapper_with_irq.sv
`default_nettype none
// Cartridge bank mapper with a scanline interrupt counter. Each item passes
// through an input register and a result register, so a transaction on the
// item channel may be taken every cycle while the result channel is not
// stalled, and its result is offered on the result channel from the result
// register; the single decode stage lies between them. CPU writes update the
// command index and bank registers, translate items map CPU or PPU addresses
// to PRG ROM, work RAM, CHR ROM or nametable offsets or to no target, and
// scanline ticks count the 32-bit counter down by 113 while it is enabled and
// report irq. Each item yields exactly one result, in order. The configuration
// channel is always ready and should be written only while the block is idle.
module banked_address_mapper_with_irq (
  input  logic         clk,
  input  logic         rst,
  bam_in_if.sink       item,
  bam_out_if.source    result,
  bam_cfg_if.sink      cfg
);

  logic                              s1_valid;
  bam_pkg::item_t                    s1_item;
  logic                              advance;
  logic                              res_valid;
  bam_pkg::target_e                  res_target;
  logic [bam_pkg::OFFSET_W-1:0]      res_offset;
  logic                              res_irq;
  bam_pkg::target_e                  map_target;
  logic [bam_pkg::OFFSET_W-1:0]      map_offset;
  logic                              map_irq;
  bam_pkg::view_t                    view;
  bam_pkg::cfg_wr_t                  cfg_wr;

  assign advance    = s1_valid && (!res_valid || result.ready);
  assign item.ready = !s1_valid || advance;
  assign cfg.ready  = 1'b1;

  assign cfg_wr.en    = cfg.valid;
  assign cfg_wr.index = cfg.index;
  assign cfg_wr.data  = cfg.data;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (item.ready) begin
      s1_valid <= item.valid;
    end
    if (item.ready && item.valid) begin
      s1_item.op   <= bam_pkg::op_e'(item.operation);
      s1_item.addr <= item.address;
      s1_item.data <= item.data;
    end
  end

  bam_state u_state (
    .clk    (clk),
    .rst    (rst),
    .commit (advance),
    .item   (s1_item),
    .cfg_wr (cfg_wr),
    .view   (view)
  );

  bam_xlate u_xlate (
    .item   (s1_item),
    .view   (view),
    .target (map_target),
    .offset (map_offset),
    .irq    (map_irq)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (result.ready) begin
      res_valid <= 1'b0;
    end
    if (advance) begin
      res_target <= map_target;
      res_offset <= map_offset;
      res_irq    <= map_irq;
    end
  end

  assign result.valid  = res_valid;
  assign result.target = res_target;
  assign result.offset = res_offset;
  assign result.irq    = res_irq;

endmodule
`default_nettype wire

>>> design/bam_state.sv
`default_nettype none
module bam_state (
  input  logic             clk,
  input  logic             rst,
  input  logic             commit,
  input  bam_pkg::item_t   item,
  input  bam_pkg::cfg_wr_t cfg_wr,
  output bam_pkg::view_t   view
);

  logic [3:0]                      command_index;
  logic [3:0][bam_pkg::DATA_W-1:0] prg_banks;
  logic [7:0][bam_pkg::DATA_W-1:0] chr_banks;
  bam_pkg::mirror_e                mirror_mode;
  logic [1:0]                      irq_control;
  logic [bam_pkg::COUNT_W-1:0]     irq_count;
  logic [bam_pkg::DATA_W-1:0]      prg_mask;
  logic [bam_pkg::DATA_W-1:0]      chr_mask;
  logic [bam_pkg::COUNT_W-1:0]     count_dec;
  logic                            is_write;

  assign count_dec = irq_count - bam_pkg::SCANLINE_CYCLES;
  assign is_write  = commit && (item.op == bam_pkg::OP_CPU_WRITE);

  always_ff @(posedge clk) begin
    if (rst) begin
      command_index <= '0;
      for (int i = 0; i < 4; i++) begin
        prg_banks[i] <= bam_pkg::DATA_W'(i);
      end
      for (int i = 0; i < 8; i++) begin
        chr_banks[i] <= bam_pkg::DATA_W'(i);
      end
      mirror_mode <= bam_pkg::MIR_VERTICAL;
      irq_control <= '0;
      irq_count   <= '0;
      prg_mask    <= '1;
      chr_mask    <= '1;
    end else begin
      if (cfg_wr.en) begin
        unique case (cfg_wr.index)
          bam_pkg::CFG_PRG_MASK: prg_mask <= cfg_wr.data;
          bam_pkg::CFG_CHR_MASK: chr_mask <= cfg_wr.data;
          default: ;
        endcase
      end
      if (is_write && item.addr[15:13] == bam_pkg::WIN_COMMAND) begin
        command_index <= item.data[3:0];
      end
      if (is_write && item.addr[15:13] == bam_pkg::WIN_DATA) begin
        unique case (command_index) inside
          [bam_pkg::CMD_CHR_FIRST:bam_pkg::CMD_CHR_LAST]:
            chr_banks[command_index[2:0]] <= item.data;
          [bam_pkg::CMD_PRG_FIRST:bam_pkg::CMD_PRG_LAST]:
            prg_banks[command_index[1:0]] <= item.data;
          bam_pkg::CMD_MIRROR: begin
            // Codes above the last mode are dropped.
            if (item.data[7:2] == '0) begin
              mirror_mode <= bam_pkg::mirror_e'(item.data[1:0]);
            end
          end
          bam_pkg::CMD_IRQ_CTRL: irq_control <= {item.data[7], item.data[0]};
          bam_pkg::CMD_COUNT_LO: irq_count <= {16'd0, irq_count[15:8], item.data};
          bam_pkg::CMD_COUNT_HI: irq_count <= {16'd0, item.data, irq_count[7:0]};
          default: ;
        endcase
      end
      if (commit && item.op == bam_pkg::OP_TICK && irq_control[1]) begin
        irq_count <= count_dec;
      end
    end
  end

  always_comb begin
    view.prg_banks = prg_banks;
    view.chr_banks = chr_banks;
    view.mirror    = mirror_mode;
    view.prg_mask  = prg_mask;
    view.chr_mask  = chr_mask;
    // Fires when the decremented count is zero or negative.
    view.tick_irq  = irq_control[1] && irq_control[0]
                     && (count_dec == '0 || count_dec[bam_pkg::COUNT_W-1]);
  end

endmodule
`default_nettype wire

>>> design/bam_xlate.sv
`default_nettype none
module bam_xlate (
  input  bam_pkg::item_t                      item,
  input  bam_pkg::view_t                      view,
  output bam_pkg::target_e                    target,
  output logic [bam_pkg::OFFSET_W-1:0]        offset,
  output logic                                irq
);

  // Translate stage between the input register and the result register.
  bam_map u_map (
    .item   (item),
    .view   (view),
    .target (target),
    .offset (offset),
    .irq    (irq)
  );

endmodule
`default_nettype wire

>>> design/bam_map.sv
`default_nettype none
module bam_map (
  input  bam_pkg::item_t                item,
  input  bam_pkg::view_t                view,
  output bam_pkg::target_e              target,
  output logic [bam_pkg::OFFSET_W-1:0]  offset,
  output logic                          irq
);

  always_comb begin
    logic [7:0] bank;
    logic [7:0] reg0;
    logic       page;
    bank   = '0;
    reg0   = view.prg_banks[0];
    page   = 1'b0;
    target = bam_pkg::TGT_NONE;
    offset = '0;
    irq    = 1'b0;
    unique case (item.op)
      bam_pkg::OP_CPU_MAP: begin
        if (item.addr[15]) begin
          if (item.addr[15:13] == bam_pkg::WIN_LAST) begin
            bank = '1;
          end else begin
            bank = view.prg_banks[item.addr[14:13] + 2'd1];
          end
          target = bam_pkg::TGT_PRG_ROM;
          offset = {bank & view.prg_mask, item.addr[12:0]};
        end else if (item.addr[15:13] == bam_pkg::WIN_WORK_RAM) begin
          if (reg0[6]) begin
            // Bit 7 enables the work RAM; otherwise the window is open bus.
            if (reg0[7]) begin
              target = bam_pkg::TGT_WORK_RAM;
              offset = {8'd0, item.addr[12:0]};
            end
          end else begin
            bank   = {2'd0, reg0[5:0]};
            target = bam_pkg::TGT_PRG_ROM;
            offset = {bank & view.prg_mask, item.addr[12:0]};
          end
        end
      end
      bam_pkg::OP_PPU_MAP: begin
        if (!item.addr[13]) begin
          bank   = view.chr_banks[item.addr[12:10]] & view.chr_mask;
          target = bam_pkg::TGT_CHR_ROM;
          offset = {3'd0, bank, item.addr[9:0]};
        end else if (item.addr[13:8] != bam_pkg::PPU_PALETTE_PAGE) begin
          unique case (view.mirror)
            bam_pkg::MIR_VERTICAL:   page = item.addr[10];
            bam_pkg::MIR_HORIZONTAL: page = item.addr[11];
            bam_pkg::MIR_SINGLE_LO:  page = 1'b0;
            bam_pkg::MIR_SINGLE_HI:  page = 1'b1;
            default:                 page = 1'b0;
          endcase
          target = bam_pkg::TGT_NAMETABLE;
          offset = {10'd0, page, item.addr[9:0]};
        end
      end
      bam_pkg::OP_TICK: irq = view.tick_irq;
      default: ;
    endcase
  end

endmodule
`default_nettype wire
